FILE: hdl/lifa_pkg.sv
// Shared types, constants and saturation helper for the LIF neuron array unit.
// No dependencies; every other file in hdl/ except lifa_state_ram imports this package.
package lifa_pkg;

    localparam int NEURONS = 1024;
    localparam int IDX_W   = $clog2(NEURONS);
    localparam int CFG_AW  = 5;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [2:0] REG_REST      = 3'd0;
    localparam logic [2:0] REG_RESET     = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_REFRACT   = 3'd3;
    localparam logic [2:0] REG_INH_REV   = 3'd4;
    localparam logic [2:0] REG_MEM_GAIN  = 3'd5;
    localparam logic [2:0] REG_THETA_INC = 3'd6;
    localparam logic [2:0] REG_THETA_DEC = 3'd7;

    typedef struct packed {
        logic              opcode;
        logic [IDX_W-1:0]  neuron_index;
        logic [31:0]       time_tick;
        logic signed [31:0] exc_input;
        logic signed [31:0] inh_input;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  neuron_out;
        logic              spiked;
        logic signed [31:0] potential;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] rest_level;
        logic signed [31:0] reset_level;
        logic signed [31:0] threshold_base;
        logic [15:0]        refractory_ticks;
        logic signed [31:0] inhibitory_reversal;
        logic [15:0]        membrane_gain;
        logic [30:0]        theta_increment;
        logic [15:0]        theta_decay_gain;
    } cfg_t;

    // One neuron entry as stored in memory.
    typedef struct packed {
        logic signed [31:0] v;
        logic signed [31:0] ge;
        logic signed [31:0] gi;
        logic signed [31:0] th;
        logic [31:0]        last;
        logic               ever;
    } nstate_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        nstate_t          data;
    } wb_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/lifa_state_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
// Generic; depends on nothing.
module lifa_state_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 161
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: hdl/lifa_apb_regs.sv
// APB configuration register file for the LIF neuron array unit.
// Depends on lifa_pkg.
module lifa_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lifa_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lifa_pkg::cfg_t             cfg
);
    import lifa_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] sel;

    assign sel    = paddr[CFG_AW-1:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (sel)
                REG_REST:      cfg_reg.rest_level          <= pwdata;
                REG_RESET:     cfg_reg.reset_level         <= pwdata;
                REG_THRESHOLD: cfg_reg.threshold_base      <= pwdata;
                REG_REFRACT:   cfg_reg.refractory_ticks    <= pwdata[15:0];
                REG_INH_REV:   cfg_reg.inhibitory_reversal <= pwdata;
                REG_MEM_GAIN:  cfg_reg.membrane_gain       <= pwdata[15:0];
                REG_THETA_INC: cfg_reg.theta_increment     <= pwdata[30:0];
                REG_THETA_DEC: cfg_reg.theta_decay_gain    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_REST:      prdata = cfg_reg.rest_level;
            REG_RESET:     prdata = cfg_reg.reset_level;
            REG_THRESHOLD: prdata = cfg_reg.threshold_base;
            REG_REFRACT:   prdata = {16'b0, cfg_reg.refractory_ticks};
            REG_INH_REV:   prdata = cfg_reg.inhibitory_reversal;
            REG_MEM_GAIN:  prdata = {16'b0, cfg_reg.membrane_gain};
            REG_THETA_INC: prdata = {1'b0, cfg_reg.theta_increment};
            REG_THETA_DEC: prdata = {16'b0, cfg_reg.theta_decay_gain};
            default:       prdata = '0;
        endcase
    end
endmodule

FILE: hdl/lifa_pipe.sv
// Six-stage neuron update pipeline with output register, hazard stall and writeback.
// Depends on lifa_pkg; state read data comes from lifa_state_ram.
module lifa_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  lifa_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  lifa_pkg::in_item_t  in_data,
    input  lifa_pkg::nstate_t   rd_data,
    output lifa_pkg::wb_t       wb,
    output logic                out_valid,
    input  logic                out_ready,
    output lifa_pkg::out_item_t out_data
);
    import lifa_pkg::*;

    localparam int NST = 6;

    typedef struct packed {
        logic               op;
        logic [IDX_W-1:0]   idx;
        logic [31:0]        tick;
        logic signed [31:0] exc;
        logic signed [31:0] inh;
        nstate_t            s;
        logic               active;
        logic signed [63:0] pe;
        logic signed [48:0] pt;
        logic signed [31:0] di;
        logic signed [32:0] rv;
        logic signed [63:0] pi;
        logic signed [31:0] ise;
        logic signed [34:0] thd;
        logic signed [31:0] drv;
        logic signed [31:0] gen;
        logic signed [31:0] gin;
        logic signed [48:0] pm;
        logic signed [31:0] vn;
    } stg_t;

    stg_t            st_reg [1:NST];
    logic [NST:1]    vld_reg;
    logic [NST:1]    mv;
    logic            out_free, acc, hazard;
    logic            m_valid_reg;
    out_item_t       m_data_reg;
    stg_t            s1in, s1x, n2, n3, n4, n5, n6;
    logic            spike;
    nstate_t         fin;
    logic signed [65:0] t_neg;

    // Stall an index that is still in flight: its entry is not yet written back.
    always_comb begin
        hazard = 1'b0;
        for (int k = 1; k <= NST; k++) begin
            if (vld_reg[k] && st_reg[k].idx == in_data.neuron_index) begin
                hazard = 1'b1;
            end
        end
    end

    always_comb begin
        out_free = !m_valid_reg || out_ready;
        mv[NST]  = vld_reg[NST] && out_free;
        for (int k = NST - 1; k >= 1; k--) begin
            mv[k] = vld_reg[k] && (!vld_reg[k+1] || mv[k+1]);
        end
    end

    assign in_ready = (!vld_reg[1] || mv[1]) && !hazard;
    assign acc      = in_valid && in_ready;

    // Stage 1 entry: input fields only, state arrives from the registered memory read in the next cycle.
    always_comb begin
        s1in      = '0;
        s1in.op   = in_data.opcode;
        s1in.idx  = in_data.neuron_index;
        s1in.tick = in_data.time_tick;
        s1in.exc  = in_data.exc_input;
        s1in.inh  = in_data.inh_input;
    end

    // Stage 1: merge state read, start products.
    always_comb begin
        s1x   = st_reg[1];
        s1x.s = rd_data;
        n2    = s1x;
        n2.active = !rd_data.ever ||
            ({2'b0, s1x.tick} > ({2'b0, rd_data.last} + 34'(cfg.refractory_ticks)));
        n2.pe = 64'(rd_data.ge) * 64'(rd_data.v);
        n2.pt = 49'(rd_data.th) * 49'($signed({1'b0, cfg.theta_decay_gain}));
        n2.di = sat32(66'(cfg.inhibitory_reversal) - 66'(rd_data.v));
        n2.rv = 33'(cfg.rest_level) - 33'(rd_data.v);
    end

    always_comb begin
        n3     = st_reg[2];
        t_neg  = -66'(st_reg[2].pe);
        n3.pi  = 64'(st_reg[2].s.gi) * 64'(st_reg[2].di);
        n3.ise = sat32(t_neg >>> 16);
        n3.thd = 35'(66'(st_reg[2].s.th) - (66'(st_reg[2].pt) >>> 16));
    end

    always_comb begin
        n4     = st_reg[3];
        n4.drv = sat32(66'(st_reg[3].rv) + 66'(st_reg[3].ise)
                       + 66'(sat32(66'(st_reg[3].pi) >>> 16)));
        n4.gen = sat32(66'(st_reg[3].s.ge) - (66'(st_reg[3].s.ge) >>> 1)
                       + 66'(st_reg[3].exc));
        n4.gin = sat32(66'(st_reg[3].s.gi) - (66'(st_reg[3].s.gi) >>> 2)
                       + 66'(st_reg[3].inh));
    end

    always_comb begin
        n5    = st_reg[4];
        n5.pm = 49'(st_reg[4].drv) * 49'($signed({1'b0, cfg.membrane_gain}));
    end

    always_comb begin
        n6    = st_reg[5];
        n6.vn = st_reg[5].active
              ? sat32(66'(st_reg[5].s.v) + (66'(st_reg[5].pm) >>> 16))
              : st_reg[5].s.v;
    end

    // Final stage: threshold compare, spike reset, offset update, or clearing of the entry for OP_CLEAR.
    always_comb begin
        stg_t f;
        f     = st_reg[NST];
        spike = (f.op == OP_UPDATE) &&
                (34'(f.vn) > (34'(cfg.threshold_base) + 34'(f.s.th)));
        fin   = f.s;
        if (f.op == OP_CLEAR) begin
            fin.v    = '0;
            fin.ge   = '0;
            fin.gi   = '0;
            fin.ever = 1'b0;
        end else begin
            fin.v    = spike ? cfg.reset_level : f.vn;
            fin.ge   = spike ? 32'sd0 : (f.active ? f.gen : f.s.ge);
            fin.gi   = spike ? 32'sd0 : (f.active ? f.gin : f.s.gi);
            fin.last = spike ? f.tick : f.s.last;
            fin.ever = spike || f.s.ever;
            fin.th   = sat32(66'(f.thd) +
                       (spike ? 66'($signed({1'b0, cfg.theta_increment})) : 66'sd0));
        end
    end

    assign wb.en   = mv[NST];
    assign wb.addr = st_reg[NST].idx;
    assign wb.data = fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            vld_reg[1] <= acc || (vld_reg[1] && !mv[1]);
            for (int k = 2; k <= NST; k++) begin
                vld_reg[k] <= mv[k-1] || (vld_reg[k] && !mv[k]);
            end
            m_valid_reg <= mv[NST] || (m_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) st_reg[1] <= s1in;
        if (mv[1]) st_reg[2] <= n2;
        if (mv[2]) st_reg[3] <= n3;
        if (mv[3]) st_reg[4] <= n4;
        if (mv[4]) st_reg[5] <= n5;
        if (mv[5]) st_reg[6] <= n6;
        if (mv[NST]) begin
            m_data_reg.neuron_out <= st_reg[NST].idx;
            m_data_reg.spiked     <= spike;
            m_data_reg.potential  <= (st_reg[NST].op == OP_CLEAR) ? 32'sd0 : fin.v;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;
endmodule

FILE: hdl/lif_neuron_array_update_unit.sv
// Top level of the conductance-based LIF neuron array update unit.
// Depends on lifa_pkg, lifa_apb_regs, lifa_state_ram and lifa_pipe.
//
//  channel   handshake            payload        direction
//  s_        s_valid / s_ready    s_data         item in
//  m_        m_valid / m_ready    m_data         result out
//  apb       psel/penable/pready  paddr/pwdata   configuration
//
// One item per cycle for distinct neurons while m_ready does not stall; an item
// passes from transfer in to result valid through the memory read, which overlaps
// stage one, five more stage advances, then the output register.
// An item whose neuron is still in flight holds until its predecessor is
// written back, so repeats of one neuron never overlap in the pipeline.
// After reset the state memory is cleared, all 1024 entries; s_ready stays low
// meanwhile, configuration writes are taken as usual.
// A stall on m_ready holds the output register; earlier stages keep
// advancing into empty slots.
module lif_neuron_array_update_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  lifa_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lifa_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lifa_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lifa_pkg::*;

    cfg_t             cfg;
    wb_t              wb;
    nstate_t          rd_data;
    logic             pipe_ready;
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    nstate_t          ram_wdata;

    lifa_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sweep the state memory to zero after reset, one entry per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == IDX_W'(NEURONS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign ram_we    = clr_busy_reg || wb.en;
    assign ram_waddr = clr_busy_reg ? clr_cnt_reg : wb.addr;
    assign ram_wdata = clr_busy_reg ? '0 : wb.data;

    // Hold off transfers until the sweep is done.
    assign s_ready = pipe_ready && !clr_busy_reg;

    lifa_state_ram #(
        .DEPTH (NEURONS),
        .WIDTH ($bits(nstate_t))
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_valid && s_ready),
        .raddr (s_data.neuron_index),
        .rdata (rd_data)
    );

    lifa_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid && !clr_busy_reg),
        .in_ready  (pipe_ready),
        .in_data   (s_data),
        .rd_data   (rd_data),
        .wb        (wb),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );
endmodule

FILE: tb/tb.sv
// Self-checking testbench for lif_neuron_array_update_unit: random and directed neuron items,
// APB register settings, and a bit-exact predictor of the neuron array. Depends on lifa_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lifa_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    lif_neuron_array_update_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor copy of the register file.
    logic signed [31:0] rest_lvl, reset_lvl, thr_base, inh_rev;
    logic [15:0]        refr_ticks, mem_gain, th_decay;
    logic [30:0]        th_inc;

    // Predictor copy of the neuron array.
    logic signed [31:0] nv   [NEURONS];
    logic signed [31:0] nge  [NEURONS];
    logic signed [31:0] ngi  [NEURONS];
    logic signed [31:0] nth  [NEURONS];
    logic [31:0]        nlast[NEURONS];
    logic               never[NEURONS];

    out_item_t  pending_results[$];
    bit         failed;
    bit         no_idle;
    int         quiet_cycles;
    logic [31:0] tick_now;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    // Advance one neuron by one item and return the result it produces.
    function automatic out_item_t lif_step(in_item_t it);
        out_item_t r;
        int        n;
        longint    v, ge, gi, th, isyn_e, isyn_i, drive;
        bit        active, spike;
        n = it.neuron_index;
        r.neuron_out = it.neuron_index;
        r.spiked = 1'b0;
        r.potential = '0;
        if (it.opcode == OP_CLEAR) begin
            nv[n] = '0;
            nge[n] = '0;
            ngi[n] = '0;
            never[n] = 1'b0;
            return r;
        end
        v = nv[n];
        ge = nge[n];
        gi = ngi[n];
        th = nth[n];
        active = !never[n] ||
            (longint'(it.time_tick) - longint'(nlast[n]) - longint'(refr_ticks) > 0);
        if (active) begin
            isyn_e = clamp32((-(ge * v)) >>> 16);
            isyn_i = clamp32((gi * clamp32(longint'(inh_rev) - v)) >>> 16);
            drive  = clamp32((longint'(rest_lvl) - v) + isyn_e + isyn_i);
            v  = clamp32(v + ((drive * longint'(mem_gain)) >>> 16));
            ge = clamp32(ge - (ge >>> 1) + longint'(it.exc_input));
            gi = clamp32(gi - (gi >>> 2) + longint'(it.inh_input));
        end
        spike = v > longint'(thr_base) + th;
        if (spike) begin
            v = reset_lvl;
            ge = 0;
            gi = 0;
            nlast[n] = it.time_tick;
            never[n] = 1'b1;
        end
        th = clamp32(th - ((th * longint'(th_decay)) >>> 16) +
                     (spike ? longint'(th_inc) : 64'sd0));
        nv[n] = v[31:0];
        nge[n] = ge[31:0];
        ngi[n] = gi[31:0];
        nth[n] = th[31:0];
        r.spiked = spike;
        r.potential = v[31:0];
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Transfer one item; call at a falling edge, returns at a falling edge.
    task automatic send_item(in_item_t it);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(lif_step(it));
        @(negedge aclk);
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Drop valid and wait until every result is back, plus pipeline slack.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_REST:      rest_lvl   = value;
            REG_RESET:     reset_lvl  = value;
            REG_THRESHOLD: thr_base   = value;
            REG_REFRACT:   refr_ticks = value[15:0];
            REG_INH_REV:   inh_rev    = value;
            REG_MEM_GAIN:  mem_gain   = value[15:0];
            REG_THETA_INC: th_inc     = value[30:0];
            REG_THETA_DEC: th_decay   = value[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_all(logic [31:0] rest, logic [31:0] rst, logic [31:0] thr,
                             logic [31:0] refr, logic [31:0] irev, logic [31:0] mg,
                             logic [31:0] tinc, logic [31:0] tdec);
        write_reg(REG_REST, rest);
        write_reg(REG_RESET, rst);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_REFRACT, refr);
        write_reg(REG_INH_REV, irev);
        write_reg(REG_MEM_GAIN, mg);
        write_reg(REG_THETA_INC, tinc);
        write_reg(REG_THETA_DEC, tdec);
    endtask

    function automatic in_item_t make_item(logic op, logic [IDX_W-1:0] idx, logic [31:0] tick,
                                           logic [31:0] exc, logic [31:0] inh);
        in_item_t it;
        it.opcode = op;
        it.neuron_index = idx;
        it.time_tick = tick;
        it.exc_input = exc;
        it.inh_input = inh;
        return it;
    endfunction

    function automatic logic [31:0] rand_q16();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
        return $urandom();
    endfunction

    // Reset defaults: everything zero, so nothing should fire.
    task automatic test_reset_defaults();
        send_item(make_item(OP_UPDATE, 10'd0, 32'd0, 32'h0001_0000, 32'd0));
        send_item(make_item(OP_UPDATE, 10'd1023, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        drain();
    endtask

    // Field extremes, clear, refractory, time going backwards.
    task automatic test_directed_edges();
        write_all(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 32'd3, 32'hFFFF_0000,
                  32'h0000_8000, 32'h0000_1000, 32'h0000_0100);
        send_item(make_item(OP_UPDATE, 10'd5, 32'd10, 32'h0000_4000, 32'h0000_2000));
        send_item(make_item(OP_UPDATE, 10'd5, 32'd11, 32'h0000_4000, 32'h0000_2000));
        send_item(make_item(OP_UPDATE, 10'd5, 32'd12, 32'd0, 32'd0));
        send_item(make_item(OP_UPDATE, 10'd5, 32'd13, 32'd0, 32'd0));
        send_item(make_item(OP_UPDATE, 10'd5, 32'd2, 32'd0, 32'd0));
        send_item(make_item(OP_UPDATE, 10'd5, 32'd30, 32'd0, 32'd0));
        send_item(make_item(OP_UPDATE, 10'd5, 32'd31, 32'd0, 32'd0));
        send_item(make_item(OP_CLEAR,  10'd5, 32'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(OP_UPDATE, 10'd5, 32'd33, 32'd0, 32'd0));
        send_item(make_item(OP_UPDATE, 10'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_item(OP_UPDATE, 10'd0, 32'd0, 32'h8000_0000, 32'h8000_0000));
        send_item(make_item(OP_UPDATE, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        send_item(make_item(OP_UPDATE, 10'd1023, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(make_item(OP_UPDATE, 10'd1023, 32'h8000_0002, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(make_item(OP_CLEAR,  10'd1023, 32'd0, 32'd0, 32'd0));
        send_item(make_item(OP_UPDATE, 10'd512, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0));
        drain();
    endtask

    // Random traffic, mostly on a small pool of neurons so their state runs deep.
    task automatic test_random_traffic(int count);
        in_item_t it;
        int       r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            it.opcode = ($urandom_range(0, 99) < 5) ? OP_CLEAR : OP_UPDATE;
            it.neuron_index = (r < 80) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom());
            if ($urandom_range(0, 19) == 0) begin
                it.time_tick = $urandom();
            end else begin
                tick_now = tick_now + $urandom_range(0, 3);
                it.time_tick = tick_now;
            end
            it.exc_input = rand_q16();
            it.inh_input = ($urandom_range(0, 3) == 0) ? 32'd0 : rand_q16();
            send_item(it);
        end
        drain();
    endtask

    task automatic test_register_extremes();
        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF, 32'h7FFF_FFFF,
                  32'h0000_FFFF, 32'h7FFF_FFFF, 32'h0000_FFFF);
        test_random_traffic(60);
        write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        test_random_traffic(60);
        write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'h8000_0000,
                  32'h0000_FFFF, 32'h7FFF_FFFF, 32'd0);
        test_random_traffic(60);
    endtask

    task automatic test_random_settings(int phases);
        for (int p = 0; p < phases; p++) begin
            no_idle = (p == 1);
            write_all($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0001_0000,
                      $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000,
                      $urandom_range(0, 32'h0002_0000),
                      $urandom_range(0, 6),
                      $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000,
                      $urandom_range(32'h1000, 32'hFFFF),
                      $urandom_range(0, 32'h0001_0000),
                      $urandom_range(0, 32'h2000));
            test_random_traffic(95);
        end
        no_idle = 1'b0;
    endtask

    // Result side: stall at random and check every transfer.
    initial begin : ready_gen
        int hold;
        int r;
        hold = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    hold = (r < 95) ? $urandom_range(0, 3) : $urandom_range(15, 50);
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result neuron=%0d spiked=%0d potential=%0d",
                         $time, m_data.neuron_out, m_data.spiked, m_data.potential);
                failed = 1'b1;
            end else begin
                want = pending_results.pop_front();
                if (m_data.neuron_out !== want.neuron_out) begin
                    $display("%0t: neuron_out expected %0d actual %0d",
                             $time, want.neuron_out, m_data.neuron_out);
                    failed = 1'b1;
                end
                if (m_data.spiked !== want.spiked) begin
                    $display("%0t: spiked expected %0d actual %0d",
                             $time, want.spiked, m_data.spiked);
                    failed = 1'b1;
                end
                if (m_data.potential !== want.potential) begin
                    $display("%0t: potential expected %h actual %h",
                             $time, want.potential, m_data.potential);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: end the run after too long without any transfer.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        failed  = 1'b0;
        no_idle = 1'b0;
        quiet_cycles = 0;
        tick_now = 32'd100;
        rest_lvl = '0; reset_lvl = '0; thr_base = '0; inh_rev = '0;
        refr_ticks = '0; mem_gain = '0; th_decay = '0; th_inc = '0;
        for (int i = 0; i < NEURONS; i++) begin
            nv[i] = '0; nge[i] = '0; ngi[i] = '0; nth[i] = '0; nlast[i] = '0; never[i] = 1'b0;
        end
        aresetn = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_directed_edges();
        test_register_extremes();
        test_random_settings(5);

        drain();
        repeat (20) @(posedge aclk);
        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
